>>> hdl/rcpfa_pkg.sv
// Shared types, constants and helpers for the refcounted page frame allocator.
package rcpfa_pkg;

	localparam int MAX_PAGES  = 1024;
	localparam int PAGE_SHIFT = 12;
	localparam int REF_BITS   = 16;
	localparam int ADDR_W     = 32;

	localparam int IDX_W = $clog2(MAX_PAGES);
	localparam int CNT_W = $clog2(MAX_PAGES + 1);
	localparam int VAL_W = (REF_BITS > IDX_W) ? REF_BITS : IDX_W;
	localparam int AW1   = ADDR_W + 1;
	localparam int DW    = ADDR_W + 2;

	localparam logic [AW1-1:0]   PAGE_MASK = (AW1'(1) << PAGE_SHIFT) - AW1'(1);
	localparam logic [VAL_W-1:0] REF_MAX   = VAL_W'((64'(1) << REF_BITS) - 64'(1));

	typedef enum logic [2:0] {
		REQ_ALLOC    = 3'd0,
		REQ_RESERVE  = 3'd1,
		REQ_REF_INC  = 3'd2,
		REQ_REF_DROP = 3'd3,
		REQ_QUERY    = 3'd4,
		REQ_INIT     = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BUSY  = 2'd1,
		ST_RANGE = 2'd2,
		ST_STATE = 2'd3
	} status_t;

	// free set: val holds the next-free link; free clear: val holds the refcount
	typedef struct packed {
		logic             free;
		logic [VAL_W-1:0] val;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} ram_wr_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] page_address;
		logic              in_range;
		logic [CNT_W-1:0]  free_pages;
	} result_t;

	function automatic logic in_region(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] base,
		logic [CNT_W-1:0] total);
		logic [AW1-1:0] off;
		off = {1'b0, a} - {1'b0, base};
		return !off[AW1-1] && ((off[ADDR_W-1:0] >> PAGE_SHIFT) < ADDR_W'(total));
	endfunction

	function automatic logic [IDX_W-1:0] page_idx(logic [ADDR_W-1:0] a,
		logic [ADDR_W-1:0] base);
		logic [ADDR_W-1:0] off;
		off = a - base;
		return IDX_W'(off >> PAGE_SHIFT);
	endfunction

endpackage

>>> hdl/refcounted_page_frame_allocator_unit.sv
// Refcounted page frame allocator: top level with request intake and response register.
// Query, empty alloc, bad init, ref outside the region and unknown codes answer straight from
// decode; alloc, other ref ops and bad reserve ranges pass through an execute or range-check state.
// Init makes one table write per page; reserve reads each page of the range, then walks the free
// list, limited by the single table read port.
// One request in flight; the next is taken once the response is handed to the output register.
// Reset (arst_n low) empties the region; the page table is undefined until init.
module refcounted_page_frame_allocator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [2:0]                   req_type,
	input  logic [rcpfa_pkg::ADDR_W-1:0] address,
	input  logic [rcpfa_pkg::ADDR_W-1:0] end_address,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [1:0]                   status,
	output logic [rcpfa_pkg::ADDR_W-1:0] page_address,
	output logic                         in_range,
	output logic [rcpfa_pkg::CNT_W-1:0]  free_pages
);
	import rcpfa_pkg::*;

	logic             start, idle, done, take, rsp_valid_q;
	result_t          res, rsp_q;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	ram_wr_t          wr;

	assign req_ready = idle;
	assign start     = req_valid && idle;
	// response slot frees up when empty or being drained this cycle
	assign take      = done && (!rsp_valid_q || rsp_ready);

	rcpfa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.address     (address),
		.end_address (end_address),
		.take        (take),
		.idle        (idle),
		.done        (done),
		.res         (res),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr          (wr)
	);

	rcpfa_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) rsp_q <= res;
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_q.status;
	assign page_address = rsp_q.page_address;
	assign in_range     = rsp_q.in_range;
	assign free_pages   = rsp_q.free_pages;

endmodule

>>> hdl/rcpfa_ram.sv
// Page table memory: one write port, one registered read port.
module rcpfa_ram (
	input  logic                        clk,
	input  rcpfa_pkg::ram_wr_t          wr,
	input  logic [rcpfa_pkg::IDX_W-1:0] rd_addr,
	output rcpfa_pkg::entry_t           rd_data
);
	import rcpfa_pkg::*;

	entry_t mem [MAX_PAGES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> hdl/rcpfa_ctrl.sv
// Request sequencer: decodes requests and runs read-modify-write over the page table.
module rcpfa_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [2:0]                   req_type,
	input  logic [rcpfa_pkg::ADDR_W-1:0] address,
	input  logic [rcpfa_pkg::ADDR_W-1:0] end_address,
	input  logic                         take,
	output logic                         idle,
	output logic                         done,
	output rcpfa_pkg::result_t           res,
	output logic [rcpfa_pkg::IDX_W-1:0]  rd_addr,
	input  rcpfa_pkg::entry_t            rd_data,
	output rcpfa_pkg::ram_wr_t           wr
);
	import rcpfa_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE      = 12'b000000000001,
		S_DEC       = 12'b000000000010,
		S_ALLOC_EX  = 12'b000000000100,
		S_REF_EX    = 12'b000000001000,
		S_INIT_FILL = 12'b000000010000,
		S_RSV_CHK   = 12'b000000100000,
		S_RSV_SRD   = 12'b000001000000,
		S_RSV_SEX   = 12'b000010000000,
		S_WALK_RD   = 12'b000100000000,
		S_WALK_EX   = 12'b001000000000,
		S_WALK_LNK  = 12'b010000000000,
		S_FIN       = 12'b100000000000
	} state_t;

	state_t            state_q;
	req_t              type_q;
	logic [ADDR_W-1:0] addr_q, pa_q;
	logic [AW1-1:0]    s_q, t_q;
	logic [ADDR_W-1:0] base_q;
	logic [CNT_W-1:0]  total_q, ftot_q;
	logic [IDX_W-1:0]  head_q, idx_q, prev_q, nxt_q;
	logic              have_prev_q;
	logic [CNT_W-1:0]  i_q, p_q, lim_q, n_q, k_q;
	logic [DW-1:0]     d_q, sb_q, tb_q;
	status_t           st_q;

	logic [DW-1:0]     dw, sbw, tbw, dw_pages;
	logic              ref_ok, hit, last, up, rsv_bad;
	logic [IDX_W-1:0]  ref_idx, nxt_rd, adv_nxt, fill_link;
	status_t           ref_st;
	entry_t            ref_new;

	assign dw       = {1'b0, t_q} - {1'b0, s_q};
	assign sbw      = {1'b0, s_q} - DW'(base_q);
	assign tbw      = {1'b0, t_q} - DW'(base_q);
	assign dw_pages = dw >> PAGE_SHIFT;
	assign ref_ok   = in_region(addr_q, base_q, total_q);
	assign ref_idx  = page_idx(addr_q, base_q);
	assign nxt_rd   = rd_data.val[IDX_W-1:0];
	assign adv_nxt  = (state_q == S_WALK_LNK) ? nxt_q : nxt_rd;
	assign hit      = (CNT_W'(idx_q) >= p_q) && (CNT_W'(idx_q) < lim_q);
	assign last     = CNT_W'(k_q + 1'b1) == ftot_q;
	assign up       = type_q == REQ_REF_INC;
	assign rsv_bad  = d_q[DW-1] || (d_q == '0) || sb_q[DW-1]
		|| ((tb_q >> PAGE_SHIFT) > DW'(total_q));
	assign fill_link = (CNT_W'(i_q + 1'b1) == total_q) ? '0 : IDX_W'(i_q + 1'b1);

	always_comb begin
		ref_new = '{free: 1'b0, val: rd_data.val - VAL_W'(1)};
		if (rd_data.free) begin
			ref_st = ST_STATE;
		end else if (up && rd_data.val >= REF_MAX) begin
			ref_st = ST_STATE;
		end else if (!up && rd_data.val == '0) begin
			ref_st = ST_STATE;
		end else begin
			ref_st = ST_OK;
		end
		if (up) begin
			ref_new = '{free: 1'b0, val: rd_data.val + VAL_W'(1)};
		end else if (rd_data.val == VAL_W'(1)) begin
			ref_new = '{free: 1'b1, val: VAL_W'(head_q)};
		end
	end

	assign rd_addr = (state_q == S_DEC) ? ((type_q == REQ_ALLOC) ? head_q : ref_idx) : idx_q;

	always_comb begin
		wr = '0;
		unique case (state_q)
			S_INIT_FILL: begin
				wr.en   = 1'b1;
				wr.addr = IDX_W'(i_q);
				wr.data = '{free: 1'b1, val: VAL_W'(fill_link)};
			end
			S_ALLOC_EX: begin
				wr.en   = 1'b1;
				wr.addr = idx_q;
				wr.data = '{free: 1'b0, val: VAL_W'(1)};
			end
			S_REF_EX: begin
				wr.en   = ref_st == ST_OK;
				wr.addr = idx_q;
				wr.data = ref_new;
			end
			S_WALK_EX: begin
				wr.en   = hit;
				wr.addr = idx_q;
				wr.data = '{free: 1'b0, val: VAL_W'(1)};
			end
			S_WALK_LNK: begin
				wr.en   = 1'b1;
				wr.addr = prev_q;
				wr.data = '{free: 1'b1, val: VAL_W'(nxt_q)};
			end
			default: wr = '0;
		endcase
	end

	assign idle = state_q == S_IDLE;
	assign done = state_q == S_FIN;
	assign res  = '{status: st_q, page_address: pa_q,
		in_range: in_region(pa_q, base_q, total_q), free_pages: ftot_q};

	// payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			type_q <= req_t'(req_type);
			addr_q <= address;
			pa_q   <= address;
			s_q    <= ({1'b0, address} + PAGE_MASK) & ~PAGE_MASK;
			t_q    <= {1'b0, end_address} & ~PAGE_MASK;
		end else if (state_q == S_ALLOC_EX) begin
			pa_q <= base_q + (ADDR_W'(idx_q) << PAGE_SHIFT);
		end
		unique case (state_q)
			S_DEC: begin
				d_q  <= dw;
				sb_q <= sbw;
				tb_q <= tbw;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			total_q     <= '0;
			head_q      <= '0;
			ftot_q      <= '0;
			st_q        <= ST_OK;
			idx_q       <= '0;
			prev_q      <= '0;
			nxt_q       <= '0;
			have_prev_q <= 1'b0;
			i_q         <= '0;
			p_q         <= '0;
			lim_q       <= '0;
			n_q         <= '0;
			k_q         <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_DEC;
				end
				S_DEC: begin
					state_q <= S_FIN;
					unique case (type_q)
						REQ_ALLOC: begin
							if (ftot_q == '0) begin
								st_q <= ST_BUSY;
							end else begin
								idx_q   <= head_q;
								state_q <= S_ALLOC_EX;
							end
						end
						REQ_REF_INC, REQ_REF_DROP: begin
							if (!ref_ok) begin
								st_q <= ST_RANGE;
							end else begin
								idx_q   <= ref_idx;
								state_q <= S_REF_EX;
							end
						end
						REQ_INIT: begin
							if (dw[DW-1] || dw == '0 || dw_pages > DW'(MAX_PAGES)) begin
								st_q <= ST_RANGE;
							end else begin
								base_q  <= s_q[ADDR_W-1:0];
								total_q <= CNT_W'(dw_pages);
								ftot_q  <= CNT_W'(dw_pages);
								head_q  <= '0;
								i_q     <= '0;
								state_q <= S_INIT_FILL;
							end
						end
						REQ_RESERVE: state_q <= S_RSV_CHK;
						REQ_QUERY:   st_q <= ST_OK;
						default:     st_q <= ST_RANGE;
					endcase
				end
				S_ALLOC_EX: begin
					head_q  <= nxt_rd;
					ftot_q  <= ftot_q - 1'b1;
					st_q    <= ST_OK;
					state_q <= S_FIN;
				end
				S_REF_EX: begin
					st_q <= ref_st;
					if (ref_st == ST_OK && !up && rd_data.val == VAL_W'(1)) begin
						head_q <= idx_q;
						ftot_q <= ftot_q + 1'b1;
					end
					state_q <= S_FIN;
				end
				S_INIT_FILL: begin
					i_q <= i_q + 1'b1;
					if (CNT_W'(i_q + 1'b1) == total_q) begin
						st_q    <= ST_OK;
						state_q <= S_FIN;
					end
				end
				S_RSV_CHK: begin
					if (rsv_bad) begin
						st_q    <= ST_RANGE;
						state_q <= S_FIN;
					end else begin
						p_q     <= CNT_W'(sb_q >> PAGE_SHIFT);
						i_q     <= CNT_W'(sb_q >> PAGE_SHIFT);
						idx_q   <= IDX_W'(sb_q >> PAGE_SHIFT);
						lim_q   <= CNT_W'(tb_q >> PAGE_SHIFT);
						n_q     <= CNT_W'(d_q >> PAGE_SHIFT);
						state_q <= S_RSV_SRD;
					end
				end
				S_RSV_SRD: state_q <= S_RSV_SEX;
				S_RSV_SEX: begin
					if (!rd_data.free) begin
						st_q    <= ST_BUSY;
						state_q <= S_FIN;
					end else if (CNT_W'(i_q + 1'b1) == lim_q) begin
						idx_q       <= head_q;
						k_q         <= '0;
						have_prev_q <= 1'b0;
						state_q     <= S_WALK_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						idx_q   <= IDX_W'(i_q + 1'b1);
						state_q <= S_RSV_SRD;
					end
				end
				S_WALK_RD: state_q <= S_WALK_EX;
				S_WALK_EX, S_WALK_LNK: begin
					if (state_q == S_WALK_EX && hit && have_prev_q) begin
						// predecessor needs relinking first
						nxt_q   <= nxt_rd;
						state_q <= S_WALK_LNK;
					end else begin
						if (state_q == S_WALK_EX) begin
							if (hit) begin
								head_q <= nxt_rd;
							end else begin
								prev_q      <= idx_q;
								have_prev_q <= 1'b1;
							end
						end
						idx_q <= adv_nxt;
						k_q   <= k_q + 1'b1;
						if (last) begin
							ftot_q  <= ftot_q - n_q;
							st_q    <= ST_OK;
							state_q <= S_FIN;
						end else begin
							state_q <= S_WALK_RD;
						end
					end
				end
				S_FIN: begin
					if (take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
